FILE: src/lpid_pkg.sv
// Shared constants and types for the lateral PID controller.
`timescale 1ns / 1ps

package lpid_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = 48;
  localparam int ACC_W     = 82;
  localparam int TICK_W    = 17;
  localparam int GAIN_W    = 32;
  localparam int SPEED_W   = 23;
  localparam int PWR_W     = 24;
  localparam int MV_W      = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int MUL_W     = 32;

  localparam logic [19:0]          DIST_K        = 20'd749613;
  localparam logic [MUL_W-1:0]     MV_FULL       = 32'd12000;
  localparam logic [MUL_W-1:0]     MV_RECIP      = 32'd8256;
  localparam logic [MUL_W-1:0]     PWR_FULL      = 32'd127;
  localparam logic [14:0]          MV_LIMIT      = 15'd12000;
  localparam logic [TICK_W-1:0]    TICK_MAX      = 17'h1FFFF;
  localparam logic [SPEED_W-1:0]   MAX_SPEED_RST = 23'h7F0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_TIMEOUT    = 3'd3,
    REG_TARGET     = 3'd4,
    REG_MAX_SPEED  = 3'd5,
    REG_MIN_SPEED  = 3'd6
  } cfg_reg_t;

endpackage

FILE: src/lpid_mul.sv
// Shared unsigned 32x32 multiplier with a registered product.
`timescale 1ns / 1ps

module lpid_mul
  import lpid_pkg::*;
(
  input  logic                 clk,
  input  logic [MUL_W-1:0]     mul_a,
  input  logic [MUL_W-1:0]     mul_b,
  output logic [2*MUL_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

FILE: src/lateral_pid_with_limits.sv
// Top level of the lateral PID controller with drive limits.
`timescale 1ns / 1ps

// One encoder sample per transfer on the input stream gives one drive result on the
// output stream. A new sample is taken only once the last one is through, because
// a single shared 32x32 multiplier computes, one after another, the distance
// conversion, the two partial products of each of the three gain terms and the three
// steps of the millivolt scaling. A tick that finds the move finished skips these
// steps. A finished result may wait in the output register while the block returns
// to idle; the next result is only written once that one has been taken.

module lateral_pid_with_limits
  import lpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // encoder_position
  input  logic                  in_tuser,   // start_req
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // drive_power, drive_millivolts, zero pad
  output logic                  out_tuser,  // finished
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIST, S_DIST_SAT, S_ERR, S_SUM, S_SEL, S_TMUL, S_TACC,
    S_CLAMP, S_FLOOR, S_MV_MUL1, S_MV_Y, S_MV_MUL2, S_MV_Q, S_MV_MUL3,
    S_MV_FIX, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [15:0]        timeout_r;
  logic signed [31:0] target_r;
  logic [SPEED_W-1:0] max_speed_r, min_speed_r;

  logic signed [31:0]    prev_err_r, prev_err_nxt;
  logic signed [SUM_W-1:0] err_sum_r, err_sum_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic                  done_r, done_nxt;

  logic                  enc_neg_r, enc_neg_nxt;
  logic [31:0]           enc_mag_r, enc_mag_nxt;
  logic signed [31:0]    dist_r, dist_nxt;
  logic signed [31:0]    err_r, err_nxt;
  logic signed [32:0]    diff_r, diff_nxt;
  logic [SUM_W-1:0]      mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [PWR_W-1:0] v_r, v_nxt;
  logic [SPEED_W-1:0]    vabs_r, vabs_nxt;
  logic                  vneg_r, vneg_nxt;
  logic [20:0]           y_r, y_nxt;
  logic [13:0]           q0_r, q0_nxt;
  logic signed [PWR_W-1:0] res_pwr_r, res_pwr_nxt;
  logic signed [MV_W-1:0]  res_mv_r, res_mv_nxt;
  logic                  res_fin_r, res_fin_nxt;
  logic signed [PWR_W-1:0] out_pwr_r, out_pwr_nxt;
  logic signed [MV_W-1:0]  out_mv_r, out_mv_nxt;
  logic                  out_fin_r, out_fin_nxt;

  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [2*MUL_W-1:0]    prod_r;

  logic                  in_fire, st_start, st_fin;
  logic [TICK_W-1:0]     tick_eff;
  logic                  done_eff;
  logic [35:0]           dist_mag;
  logic signed [32:0]    err_wide;
  logic signed [SUM_W:0] sum_wide;
  logic signed [SUM_W:0] term_x;
  logic [SUM_W:0]        term_mag;
  logic [GAIN_W-1:0]     term_gain;
  logic [ACC_W-1:0]      pp;
  logic signed [65:0]    scaled;
  logic signed [65:0]    lim;
  logic signed [PWR_W-1:0] vabs_full;
  logic [SPEED_W-1:0]    vabs_fl;
  logic [20:0]           rem;
  logic [14:0]           q_fix;
  logic                  out_load;

  lpid_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_mv_r, out_pwr_r};
  assign out_tuser  = out_fin_r;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);

  assign st_start = in_tuser;
  assign tick_eff = st_start ? '0 : tick_r;
  assign done_eff = st_start ? 1'b0 : done_r;
  assign st_fin   = done_eff || (tick_eff > {1'b0, timeout_r});

  always_comb begin
    unique case (cnt_r[2:1])
      2'd0: begin
        term_x    = {{17{err_r[31]}}, err_r};
        term_gain = gain_p_r;
      end
      2'd1: begin
        term_x    = {err_sum_r[SUM_W-1], err_sum_r};
        term_gain = gain_i_r;
      end
      default: begin
        term_x    = {{16{diff_r[32]}}, diff_r};
        term_gain = gain_d_r;
      end
    endcase
    term_mag = term_x[SUM_W] ? -term_x : term_x;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DIST: begin
        mul_a = {12'b0, DIST_K};
        mul_b = enc_mag_r;
      end
      S_TMUL: begin
        mul_a = term_gain;
        mul_b = cnt_r[0] ? {16'b0, mag_r[47:32]} : mag_r[31:0];
      end
      S_MV_MUL1: begin
        mul_a = {9'b0, vabs_r};
        mul_b = MV_FULL;
      end
      S_MV_MUL2: begin
        mul_a = {11'b0, y_r};
        mul_b = MV_RECIP;
      end
      S_MV_MUL3: begin
        mul_a = {18'b0, q0_r};
        mul_b = PWR_FULL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    prev_err_nxt  = prev_err_r;
    err_sum_nxt   = err_sum_r;
    tick_nxt      = tick_r;
    done_nxt      = done_r;
    enc_neg_nxt   = enc_neg_r;
    enc_mag_nxt   = enc_mag_r;
    dist_nxt      = dist_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    v_nxt         = v_r;
    vabs_nxt      = vabs_r;
    vneg_nxt      = vneg_r;
    y_nxt         = y_r;
    q0_nxt        = q0_r;
    res_pwr_nxt   = res_pwr_r;
    res_mv_nxt    = res_mv_r;
    res_fin_nxt   = res_fin_r;
    dist_mag      = prod_r[51:16];
    err_wide      = {target_r[31], target_r} - {dist_r[31], dist_r};
    sum_wide      = {err_sum_r[SUM_W-1], err_sum_r} + {{17{err_r[31]}}, err_r};
    pp            = cnt_r[0] ? {prod_r[49:0], 32'b0} : {18'b0, prod_r};
    scaled        = 66'(acc_r >>> FRAC_BITS);
    lim           = {43'b0, max_speed_r};
    vabs_full     = v_r[PWR_W-1] ? -v_r : v_r;
    vabs_fl       = (vabs_full[SPEED_W-1:0] < min_speed_r) ? min_speed_r
                                                           : vabs_full[SPEED_W-1:0];
    rem           = y_r - prod_r[20:0];
    q_fix         = (rem >= 21'd127) ? {1'b0, q0_r} + 15'd1 : {1'b0, q0_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tick_nxt = tick_eff;
          if (st_start) begin
            prev_err_nxt = '0;
            err_sum_nxt  = '0;
          end
          if (st_fin) begin
            done_nxt    = 1'b1;
            res_pwr_nxt = '0;
            res_mv_nxt  = '0;
            res_fin_nxt = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            done_nxt    = 1'b0;
            enc_neg_nxt = in_tdata[31];
            enc_mag_nxt = in_tdata[31] ? -in_tdata : in_tdata;
            state_nxt   = S_DIST;
          end
        end
      end
      S_DIST: begin
        state_nxt = S_DIST_SAT;
      end
      S_DIST_SAT: begin
        if (enc_neg_r) begin
          dist_nxt = (dist_mag > 36'h080000000) ? 32'sh80000000 : -dist_mag[31:0];
        end else begin
          dist_nxt = (dist_mag > 36'h07FFFFFFF) ? 32'sh7FFFFFFF : dist_mag[31:0];
        end
        state_nxt = S_ERR;
      end
      S_ERR: begin
        if (err_wide[32] != err_wide[31]) begin
          err_nxt = err_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
          err_nxt = err_wide[31:0];
        end
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
          err_sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          err_sum_nxt = sum_wide[SUM_W-1:0];
        end
        diff_nxt     = {err_r[31], err_r} - {prev_err_r[31], prev_err_r};
        prev_err_nxt = err_r;
        if (tick_r < TICK_MAX) begin
          tick_nxt = tick_r + 17'd1;
        end
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        mag_nxt   = term_mag[SUM_W-1:0];
        neg_nxt   = term_x[SUM_W];
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        state_nxt = S_TACC;
      end
      S_TACC: begin
        acc_nxt = neg_r ? acc_r - $signed(pp) : acc_r + $signed(pp);
        if (cnt_r == 3'd5) begin
          state_nxt = S_CLAMP;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = cnt_r[0] ? S_SEL : S_TMUL;
        end
      end
      S_CLAMP: begin
        priority if (scaled > lim) begin
          v_nxt = lim[PWR_W-1:0];
        end else if (scaled < -lim) begin
          v_nxt = -lim[PWR_W-1:0];
        end else begin
          v_nxt = scaled[PWR_W-1:0];
        end
        state_nxt = S_FLOOR;
      end
      S_FLOOR: begin
        vneg_nxt  = v_r[PWR_W-1];
        vabs_nxt  = vabs_fl;
        state_nxt = S_MV_MUL1;
      end
      S_MV_MUL1: begin
        state_nxt = S_MV_Y;
      end
      S_MV_Y: begin
        y_nxt     = prod_r[36:16];
        state_nxt = S_MV_MUL2;
      end
      S_MV_MUL2: begin
        state_nxt = S_MV_Q;
      end
      S_MV_Q: begin
        q0_nxt    = prod_r[33:20];
        state_nxt = S_MV_MUL3;
      end
      S_MV_MUL3: begin
        state_nxt = S_MV_FIX;
      end
      S_MV_FIX: begin
        if (q_fix > MV_LIMIT) begin
          res_mv_nxt = vneg_r ? -MV_LIMIT : MV_LIMIT;
        end else begin
          res_mv_nxt = vneg_r ? -q_fix : q_fix;
        end
        res_pwr_nxt = vneg_r ? -{1'b0, vabs_r} : {1'b0, vabs_r};
        res_fin_nxt = 1'b0;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_pwr_nxt   = out_pwr_r;
    out_mv_nxt    = out_mv_r;
    out_fin_nxt   = out_fin_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_pwr_nxt   = res_pwr_r;
      out_mv_nxt    = res_mv_r;
      out_fin_nxt   = res_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      err_sum_r   <= '0;
      tick_r      <= '0;
      done_r      <= 1'b0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      timeout_r   <= '0;
      target_r    <= '0;
      max_speed_r <= MAX_SPEED_RST;
      min_speed_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      prev_err_r  <= prev_err_nxt;
      err_sum_r   <= err_sum_nxt;
      tick_r      <= tick_nxt;
      done_r      <= done_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_GAIN_P:    gain_p_r    <= cfg_wdata;
          REG_GAIN_I:    gain_i_r    <= cfg_wdata;
          REG_GAIN_D:    gain_d_r    <= cfg_wdata;
          REG_TIMEOUT:   timeout_r   <= cfg_wdata[15:0];
          REG_TARGET:    target_r    <= cfg_wdata;
          REG_MAX_SPEED: max_speed_r <= cfg_wdata[SPEED_W-1:0];
          REG_MIN_SPEED: min_speed_r <= cfg_wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    enc_neg_r <= enc_neg_nxt;
    enc_mag_r <= enc_mag_nxt;
    dist_r    <= dist_nxt;
    err_r     <= err_nxt;
    diff_r    <= diff_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    acc_r     <= acc_nxt;
    v_r       <= v_nxt;
    vabs_r    <= vabs_nxt;
    vneg_r    <= vneg_nxt;
    y_r       <= y_nxt;
    q0_r      <= q0_nxt;
    res_pwr_r <= res_pwr_nxt;
    res_mv_r  <= res_mv_nxt;
    res_fin_r <= res_fin_nxt;
    out_pwr_r <= out_pwr_nxt;
    out_mv_r  <= out_mv_nxt;
    out_fin_r <= out_fin_nxt;
  end

endmodule

FILE: src/lpid_checker.sv
// Port-level assertions for the lateral PID controller and their binding.
`timescale 1ns / 1ps

module lpid_checker
  import lpid_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transfer changed while stalled");

  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 40'd0)
    else $error("finished result carries a nonzero drive");

  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[38:24]) <= $signed(MV_LIMIT))
                && ($signed(out_tdata[38:24]) >= -$signed(MV_LIMIT)))
    else $error("millivolt output out of range");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again right after a transfer");

endmodule

bind lateral_pid_with_limits lpid_checker u_lpid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/lpid_drive_checker.sv
// Checker that mirrors register writes, predicts each drive result and compares the outputs.
`timescale 1ns / 1ps

module lpid_drive_checker
  import lpid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [31:0]          in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,
  input  logic                 out_tuser,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic signed [PWR_W-1:0] power;
    logic signed [MV_W-1:0]  mv;
    logic                    fin;
  } drive_t;

  drive_t drive_due[$];

  logic [GAIN_W-1:0]        kp, ki, kd;
  logic [15:0]              timeout;
  logic signed [31:0]       target;
  logic [SPEED_W-1:0]       max_spd, min_spd;
  logic signed [31:0]       last_err;
  logic signed [SUM_W-1:0]  err_sum;
  logic [TICK_W-1:0]        ticks;
  logic                     done;

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [127:0] gain_term(input logic [31:0] g, input longint x);
    logic signed [127:0] a, b;
    a = {96'd0, g};
    b = x;
    return a * b;
  endfunction

  function automatic drive_t next_drive(input logic start, input logic signed [31:0] enc);
    longint scaled, dist_q, err, sum, diff, v, lim, mag, mv;
    logic signed [127:0] acc;
    drive_t r;
    r = '0;
    if (start) begin
      last_err = '0;
      err_sum  = '0;
      ticks    = '0;
      done     = 1'b0;
    end
    if (!done && ticks > timeout) done = 1'b1;
    if (done) begin
      r.fin = 1'b1;
      return r;
    end
    scaled = longint'(enc) * longint'(DIST_K);
    dist_q = (scaled < 0) ? -((-scaled) >>> (32 - FRAC_BITS))
                          : (scaled >>> (32 - FRAC_BITS));
    dist_q = clip32(dist_q);
    err  = clip32(longint'(target) - dist_q);
    sum  = longint'(err_sum) + err;
    if (sum > SUM_HI) sum = SUM_HI;
    else if (sum < SUM_LO) sum = SUM_LO;
    diff = err - longint'(last_err);
    acc  = gain_term(kp, err) + gain_term(ki, sum) + gain_term(kd, diff);
    acc  = acc >>> FRAC_BITS;
    lim  = longint'(max_spd);
    if (acc > lim) v = lim;
    else if (acc < -lim) v = -lim;
    else v = longint'(acc);
    if (((v < 0) ? -v : v) < longint'(min_spd))
      v = (v < 0) ? -longint'(min_spd) : longint'(min_spd);
    mag = ((v < 0) ? -v : v) * longint'(MV_FULL);
    mag = mag / (longint'(PWR_FULL) <<< FRAC_BITS);
    if (mag > longint'(MV_LIMIT)) mag = longint'(MV_LIMIT);
    mv = (v < 0) ? -mag : mag;
    err_sum  = sum[SUM_W-1:0];
    last_err = err[31:0];
    if (ticks != TICK_MAX) ticks = ticks + 1'b1;
    r.power = v[PWR_W-1:0];
    r.mv    = mv[MV_W-1:0];
    r.fin   = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      kp = '0;
      ki = '0;
      kd = '0;
      timeout = '0;
      target = '0;
      max_spd = MAX_SPEED_RST;
      min_spd = '0;
      last_err = '0;
      err_sum = '0;
      ticks = '0;
      done = 1'b0;
      drive_due.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_due.size() == 0) begin
          $error("Result transfer with no tick outstanding: tdata %h, tuser %b",
                 out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = drive_due.pop_front();
          if ($signed(out_tdata[23:0]) != want.power) begin
            $error("drive_power: expected %0d, got %0d", want.power, $signed(out_tdata[23:0]));
            mismatches++;
          end
          if ($signed(out_tdata[38:24]) != want.mv) begin
            $error("drive_millivolts: expected %0d, got %0d", want.mv,
                   $signed(out_tdata[38:24]));
            mismatches++;
          end
          if (out_tuser != want.fin) begin
            $error("finished: expected %0d, got %0d", want.fin, out_tuser);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GAIN_P:    kp = cfg_wdata;
          REG_GAIN_I:    ki = cfg_wdata;
          REG_GAIN_D:    kd = cfg_wdata;
          REG_TIMEOUT:   timeout = cfg_wdata[15:0];
          REG_TARGET:    target = cfg_wdata;
          REG_MAX_SPEED: max_spd = cfg_wdata[SPEED_W-1:0];
          REG_MIN_SPEED: min_spd = cfg_wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) drive_due.push_back(next_drive(in_tuser, in_tdata));
    end
    pending = drive_due.size();
  end

endmodule

FILE: tb/tb_lateral_pid_with_limits.sv
// Testbench top for the lateral PID controller: clock, reset, register writes and stimulus.
`timescale 1ns / 1ps

module tb_lateral_pid_with_limits;
  import lpid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int  mismatches;
  int  pending;
  int  cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stall_on = 1'b1;
  int  aim_enc = 0;

  lateral_pid_with_limits DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  lpid_drive_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= !stall_on || ($urandom_range(99) >= 20);
  end

  task automatic send_sample(input logic start, input logic [31:0] enc);
    if (gaps_on && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= enc;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h40_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_enc();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return aim_enc + int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  initial begin
    int tmo, tgt, spd_max, spd_min, sent, run;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero gains and zero timeout, so the second tick already ends the move.
    send_sample(1'b0, 32'd0);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b1, 32'h8000_0000);
    drain();

    write_reg(REG_GAIN_P, 32'h0001_0000);
    write_reg(REG_GAIN_I, 32'h0000_0800);
    write_reg(REG_GAIN_D, 32'h0000_8000);
    write_reg(REG_TIMEOUT, 32'd4);
    write_reg(REG_TARGET, 32'h0010_0000);
    write_reg(REG_MAX_SPEED, 32'h007F_0000);
    write_reg(REG_MIN_SPEED, 32'h0002_0000);
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd91673);
    send_sample(1'b0, 32'd91673);
    send_sample(1'b0, 32'd1);
    send_sample(1'b1, 32'd91673);
    send_sample(1'b1, 32'd91680);
    drain();

    // Floor above ceiling with saturating gains.
    write_reg(REG_GAIN_P, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_I, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_D, 32'hFFFF_FFFF);
    write_reg(REG_TIMEOUT, 32'd65535);
    write_reg(REG_TARGET, 32'h8000_0000);
    write_reg(REG_MAX_SPEED, 32'd0);
    write_reg(REG_MIN_SPEED, 32'h0001_0000);
    send_sample(1'b1, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b0, 32'd0);
    drain();

    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    write_reg(REG_MAX_SPEED, 32'd8323072);
    write_reg(REG_MIN_SPEED, 32'd8323072);
    send_sample(1'b1, 32'h8000_0000);
    send_sample(1'b0, 32'h7FFF_FFFF);
    drain();
    write_reg(REG_MIN_SPEED, 32'd0);
    send_sample(1'b1, 32'h8000_0000);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      gaps_on  = (ph != 0);
      stall_on = (ph != 0);
      case ($urandom_range(9))
        0: tmo = 0;
        1: tmo = 65535;
        default: tmo = $urandom_range(1, 40);
      endcase
      case ($urandom_range(9))
        0: tgt = 32'h7FFF_FFFF;
        1: tgt = 32'h8000_0000;
        default: tgt = int'($urandom_range(0, 32'h100_0000)) - 32'h80_0000;
      endcase
      case ($urandom_range(5))
        0: spd_max = 0;
        1: spd_max = 8323072;
        default: spd_max = $urandom_range(32'h1_0000, 8323072);
      endcase
      case ($urandom_range(5))
        0: spd_min = 0;
        1: spd_min = $urandom_range(spd_max, 8323072);
        default: spd_min = $urandom_range(0, spd_max / 4);
      endcase
      aim_enc = int'(longint'(tgt) * 65536 / 749613);
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, ($urandom_range(3) == 0) ? rand_gain() : $urandom_range(0, 32'h2000));
      write_reg(REG_GAIN_D, rand_gain());
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_TARGET, tgt);
      write_reg(REG_MAX_SPEED, spd_max);
      write_reg(REG_MIN_SPEED, spd_min);
      sent = 0;
      while (sent < 50) begin
        run = $urandom_range(1, (tmo > 57) ? 60 : tmo + 3);
        send_sample(1'b1, rand_enc());
        sent++;
        for (int k = 0; k < run && sent < 50; k++) begin
          send_sample($urandom_range(99) < 5, rand_enc());
          sent++;
        end
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lpid_pkg.sv
src/lpid_mul.sv
src/lateral_pid_with_limits.sv
src/lpid_checker.sv
tb/lpid_drive_checker.sv
tb/tb_lateral_pid_with_limits.sv
